/* rtl/core/opdpt_pkg.sv */
package opdpt_pkg;

    // Field widths fixed by the item formats
    localparam int KIND_W     = 4;
    localparam int DEV_W      = 8;
    localparam int ID_W       = 10;
    localparam int OCNT_W     = 2;
    localparam int ERR_W      = 7;
    localparam int DCNT_W     = 5;
    localparam int DDEV_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Defaults for the top-level parameters
    localparam int MAX_DEVICES_DEF = 16;
    localparam int VALUE_IDS_DEF   = 1024;

    // Schedule epoch tag kept beside each value table entry
    localparam int                 EPOCH_W   = 6;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
    localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

    // Classified item queue between front and back
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;
    localparam logic [QCNT_W-1:0] QUEUE_DEPTH = QCNT_W'(2);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_DEVICE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY            = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESERVE_ASSIGNED = 2'd3;

    // Configuration reset values
    localparam logic [DCNT_W-1:0] DEVICE_COUNT_RST = DCNT_W'(1);

    // Operation kinds
    localparam logic [KIND_W-1:0] KIND_UPLOAD_PLAIN = 4'd0;
    localparam logic [KIND_W-1:0] KIND_UPLOAD_CIPHER = 4'd1;
    localparam logic [KIND_W-1:0] KIND_COPY_PLAIN   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_COPY_CIPHER  = 4'd3;
    localparam logic [KIND_W-1:0] KIND_DOWNLOAD     = 4'd4;

    // Policy codes
    localparam logic POLICY_ROUND_ROBIN = 1'b1;

    // Unassigned device marker
    localparam logic signed [DEV_W-1:0] DEV_UNASSIGNED = -8'sd1;

    // Error bit positions
    localparam int ERR_CONFIG    = 0;
    localparam int ERR_ASSIGNED  = 1;
    localparam int ERR_UNKNOWN   = 2;
    localparam int ERR_COPY      = 3;
    localparam int ERR_COUNT     = 4;
    localparam int ERR_RESERVED  = 5;
    localparam int ERR_DUPLICATE = 6;

    typedef struct packed {
        logic                    begin_req;
        logic [KIND_W-1:0]       kind;
        logic signed [DEV_W-1:0] assigned_device;
        logic                    has_input;
        logic [ID_W-1:0]         first_input_id;
        logic [OCNT_W-1:0]       output_count;
        logic [ID_W-1:0]         out_value_id;
    } in_item_t;

    typedef struct packed {
        logic                    placed;
        logic signed [DEV_W-1:0] device;
        logic [ERR_W-1:0]        errors;
    } out_item_t;

    typedef struct packed {
        logic [DCNT_W-1:0] dev_count;
        logic [DDEV_W-1:0] home_dev;
        logic              policy;
        logic              preserve_assigned;
    } cfg_t;

    // Device source chosen by the front
    typedef enum logic [1:0] {
        SEL_DEFAULT,
        SEL_KEPT,
        SEL_LOOKUP,
        SEL_RR
    } sel_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic             begin_req;
        logic             cfg_bad;
        sel_t             sel;
        logic [DEV_W-1:0] assigned;
        logic             keep_bad;
        logic             err_copy;
        logic             in_id_ok;
        logic [ID_W-1:0]  in_id;
        logic             record_try;
        logic             err_count;
        logic             err_reserved;
        logic [ID_W-1:0]  out_id;
    } cls_t;

    // Back part sequencer
    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

endpackage

/* rtl/core/opdpt_ram.sv */
module opdpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register both reads
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* rtl/core/opdpt_front.sv */
module opdpt_front #(
    parameter int MAX_DEVICES = 16,
    parameter int VALUE_IDS   = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  opdpt_pkg::in_item_t item,
    input  opdpt_pkg::cfg_t     cfg,
    input  logic               pop,
    output opdpt_pkg::cls_t     head,
    output logic               head_valid,
    output logic               full
);

    import opdpt_pkg::*;

    cls_t              cls;
    cls_t              q_reg [2];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              assigned_out;
    logic              out_id_ok;

    // Classify the incoming item against the current configuration
    always_comb
    begin
        cls = '0;
        cls.begin_req = item.begin_req;
        cls.cfg_bad   = (item.begin_req & 1'b0)
                      | (cfg.dev_count == '0)
                      | (32'(cfg.dev_count) > MAX_DEVICES)
                      | ({1'b0, cfg.home_dev} >= cfg.dev_count);
        cls.assigned  = item.assigned_device;
        cls.in_id     = item.first_input_id;
        cls.out_id    = item.out_value_id;
        cls.in_id_ok  = 32'(item.first_input_id) < VALUE_IDS;
        out_id_ok     = (item.out_value_id != '0) && (32'(item.out_value_id) < VALUE_IDS);
        assigned_out  = item.assigned_device[DEV_W-1]
                      | ({1'b0, item.assigned_device[DEV_W-2:0]}
                         >= DEV_W'(cfg.dev_count));

        // Pick the device source
        if (cfg.preserve_assigned && (item.assigned_device != DEV_UNASSIGNED))
        begin
            cls.sel      = SEL_KEPT;
            cls.keep_bad = assigned_out;
        end
        else
        begin
            case (item.kind) inside
                [KIND_UPLOAD_PLAIN:KIND_UPLOAD_CIPHER]:
                begin
                    cls.sel = SEL_DEFAULT;
                end
                [KIND_COPY_PLAIN:KIND_COPY_CIPHER]:
                begin
                    cls.sel      = SEL_DEFAULT;
                    cls.err_copy = 1'b1;
                end
                KIND_DOWNLOAD:
                begin
                    cls.sel = item.has_input ? SEL_LOOKUP : SEL_DEFAULT;
                end
                default:
                begin
                    cls.sel = (cfg.policy == POLICY_ROUND_ROBIN) ? SEL_RR : SEL_DEFAULT;
                end
            endcase
        end

        // Check the output value
        if ((item.kind != KIND_DOWNLOAD) && (item.output_count != '0))
        begin
            if (item.output_count != OCNT_W'(1))
            begin
                cls.err_count = 1'b1;
            end
            else if (!out_id_ok)
            begin
                cls.err_reserved = 1'b1;
            end
            else
            begin
                cls.record_try = 1'b1;
            end
        end
    end

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold classified items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = cnt_reg != '0;
    assign full       = cnt_reg == QUEUE_DEPTH;

endmodule

/* rtl/core/opdpt_back.sv */
module opdpt_back #(
    parameter int MAX_DEVICES = 16,
    parameter int VALUE_IDS   = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  opdpt_pkg::cfg_t      cfg,
    input  opdpt_pkg::cls_t      head,
    input  logic                head_valid,
    output logic                pop,
    output logic                clearing,
    output logic                done,
    output opdpt_pkg::out_item_t result
);

    import opdpt_pkg::*;

    localparam int ADDR_W = $clog2(VALUE_IDS);
    localparam int PTR_W  = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int WORD_W = EPOCH_W + DEV_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(VALUE_IDS - 1);

    state_t             state_reg;
    state_t             state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic [ADDR_W-1:0]  clr_cnt_next;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [EPOCH_W-1:0] epoch_next;
    logic [PTR_W-1:0]   ptr_reg;
    logic [PTR_W-1:0]   ptr_next;
    logic               s1_valid_reg;
    cls_t               s1_reg;
    logic               fwd_en_reg;
    logic [ADDR_W-1:0]  fwd_addr_reg;
    logic [WORD_W-1:0]  fwd_word_reg;
    logic               done_reg;
    out_item_t          result_reg;
    out_item_t          result_next;

    logic               begin_hold;
    logic               wrap_start;
    logic [EPOCH_W-1:0] epoch_eff;
    logic [ADDR_W-1:0]  s1_in_addr;
    logic [ADDR_W-1:0]  s1_out_addr;
    logic [WORD_W-1:0]  rd_in;
    logic [WORD_W-1:0]  rd_out;
    logic [WORD_W-1:0]  in_word;
    logic [WORD_W-1:0]  out_word;
    logic               in_known;
    logic               out_taken;
    logic [PTR_W-1:0]   ptr_cur;
    logic [PTR_W-1:0]   rr_dev;
    logic [DEV_W-1:0]   dev;
    logic [ERR_W-1:0]   errs;
    logic               fin_we;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;

    opdpt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (VALUE_IDS)
    ) u_table (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ADDR_W'(head.in_id)),
        .rdata_a (rd_in),
        .raddr_b (ADDR_W'(head.out_id)),
        .rdata_b (rd_out)
    );

    // Issue: a new schedule waits for the stage ahead and for epoch wrap
    always_comb
    begin
        begin_hold = head.begin_req && (s1_valid_reg || (epoch_reg == EPOCH_MAX));
        pop        = head_valid && (state_reg == ST_RUN) && !begin_hold;
        wrap_start = head_valid && (state_reg == ST_RUN) && head.begin_req
                   && !s1_valid_reg && (epoch_reg == EPOCH_MAX);
    end

    // Finish: resolve lookups with forwarding from the last write
    always_comb
    begin
        epoch_eff   = s1_reg.begin_req ? epoch_reg + 1'b1 : epoch_reg;
        s1_in_addr  = ADDR_W'(s1_reg.in_id);
        s1_out_addr = ADDR_W'(s1_reg.out_id);
        in_word     = (fwd_en_reg && (fwd_addr_reg == s1_in_addr)) ? fwd_word_reg : rd_in;
        out_word    = (fwd_en_reg && (fwd_addr_reg == s1_out_addr)) ? fwd_word_reg : rd_out;
        in_known    = s1_reg.in_id_ok && (in_word[WORD_W-1:DEV_W] == epoch_eff);
        out_taken   = out_word[WORD_W-1:DEV_W] == epoch_eff;

        // Round-robin pick, stale pointer falls back to device 0
        ptr_cur = s1_reg.begin_req ? '0 : ptr_reg;
        rr_dev  = (32'(ptr_cur) < 32'(cfg.dev_count)) ? ptr_cur : '0;

        dev  = DEV_W'(cfg.home_dev);
        errs = '0;
        case (s1_reg.sel)
            SEL_KEPT:
            begin
                dev                = s1_reg.assigned;
                errs[ERR_ASSIGNED] = s1_reg.keep_bad;
            end
            SEL_LOOKUP:
            begin
                if (in_known)
                begin
                    dev = in_word[DEV_W-1:0];
                end
                else
                begin
                    errs[ERR_UNKNOWN] = 1'b1;
                end
            end
            SEL_RR:
            begin
                dev = DEV_W'(rr_dev);
            end
            default:
            begin
                dev = DEV_W'(cfg.home_dev);
            end
        endcase
        errs[ERR_COPY]      = s1_reg.err_copy;
        errs[ERR_COUNT]     = s1_reg.err_count;
        errs[ERR_RESERVED]  = s1_reg.err_reserved;
        errs[ERR_DUPLICATE] = s1_reg.record_try && out_taken;

        fin_we = s1_valid_reg && !s1_reg.cfg_bad && s1_reg.record_try && !out_taken;

        // Result, or a config-only flag when the setup is bad
        if (s1_reg.cfg_bad)
        begin
            result_next             = '0;
            result_next.errors[ERR_CONFIG] = 1'b1;
        end
        else
        begin
            result_next.placed = 1'b1;
            result_next.device = dev;
            result_next.errors = errs;
        end

        // Advance the pointer
        ptr_next = ptr_reg;
        if (s1_valid_reg)
        begin
            if (!s1_reg.cfg_bad && (s1_reg.sel == SEL_RR))
            begin
                ptr_next = (32'(rr_dev) + 1 >= 32'(cfg.dev_count)) ? '0 : rr_dev + 1'b1;
            end
            else
            begin
                ptr_next = ptr_cur;
            end
        end
    end

    // Sequencer: clearing pass and epoch
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        epoch_next   = epoch_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_RUN;
                    epoch_next = EPOCH_ONE;
                end
            end
            ST_RUN:
            begin
                if (s1_valid_reg && s1_reg.begin_req)
                begin
                    epoch_next = epoch_reg + 1'b1;
                end
                if (wrap_start)
                begin
                    state_next   = ST_CLEAR;
                    clr_cnt_next = '0;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Table write port
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = fin_we;
            ram_waddr = s1_out_addr;
            ram_wdata = {epoch_eff, dev};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            epoch_reg    <= EPOCH_ONE;
            ptr_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_en_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            epoch_reg    <= epoch_next;
            ptr_reg      <= ptr_next;
            s1_valid_reg <= pop;
            fwd_en_reg   <= ram_we;
            done_reg     <= s1_valid_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_reg <= head;
        end
        fwd_addr_reg <= ram_waddr;
        fwd_word_reg <= ram_wdata;
        if (s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign clearing = state_reg == ST_CLEAR;
    assign done     = done_reg;
    assign result   = result_reg;

endmodule

/* rtl/core/op_device_placement_tracker_core.sv */
// Channel  | Ports                               | Handshake
// ---------+-------------------------------------+------------------------------------
// item in  | start, busy, item                   | taken when start high, busy low
// result   | done, result                        | one-cycle strobe, no back-pressure
// config   | cfg_we, cfg_index, cfg_data         | written when cfg_we high
//
// Items are classified on acceptance into a two-entry queue; unless a clearing
// pass runs or a new schedule waits, the back part takes one a cycle, so one item
// per cycle is sustained. A result passes the queue, the s1 stage and the result
// register. An item opening a new schedule waits behind an item still in flight.
// After reset, and every 2^6-2 new schedules when the epoch tag of the value table
// wraps, a clearing pass writes all entries, busy high. The receiver cannot stall.
module op_device_placement_tracker_core #(
    parameter int MAX_DEVICES = opdpt_pkg::MAX_DEVICES_DEF,
    parameter int VALUE_IDS   = opdpt_pkg::VALUE_IDS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  opdpt_pkg::in_item_t                      item,
    output logic                                    done,
    output opdpt_pkg::out_item_t                     result,
    input  logic                                    cfg_we,
    input  logic [opdpt_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [opdpt_pkg::CFG_DATA_W-1:0]        cfg_data
);

    import opdpt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    cls_t head;
    logic head_valid;
    logic pop;
    logic full;
    logic clearing;
    logic push;

    // Write configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_COUNT:      cfg_next.dev_count         = cfg_data[DCNT_W-1:0];
                CFG_DEFAULT_DEVICE:    cfg_next.home_dev          = cfg_data[DDEV_W-1:0];
                CFG_POLICY:            cfg_next.policy            = cfg_data[0];
                CFG_PRESERVE_ASSIGNED: cfg_next.preserve_assigned = cfg_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dev_count         <= DEVICE_COUNT_RST;
            cfg_reg.home_dev          <= '0;
            cfg_reg.policy            <= 1'b0;
            cfg_reg.preserve_assigned <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept while the queue has room and no clearing pass runs
    assign busy = full || clearing;
    assign push = start && !busy;

    opdpt_front #(
        .MAX_DEVICES (MAX_DEVICES),
        .VALUE_IDS   (VALUE_IDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .cfg        (cfg_reg),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    opdpt_back #(
        .MAX_DEVICES (MAX_DEVICES),
        .VALUE_IDS   (VALUE_IDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .clearing   (clearing),
        .done       (done),
        .result     (result)
    );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import opdpt_pkg::*;

    localparam int IDS           = VALUE_IDS_DEF;
    localparam int QUIET_LIMIT   = 6000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 38;
    localparam int IN_W          = $bits(in_item_t);

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    in_item_t              item      = '0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  busy;
    logic                  done;
    out_item_t             result;

    // Shadow of the configuration registers
    int unsigned n_devices     = 1;
    int unsigned home_device   = 0;
    logic        rr_policy     = 1'b0;
    logic        keep_assigned = 1'b1;

    // Shadow of the schedule state
    logic [IDS-1:0]   value_seen = '0;
    logic [DEV_W-1:0] value_home [IDS];
    int unsigned      rr_next = 0;

    in_item_t  ops_waiting [$];
    out_item_t placement_due [$];
    int        idle_pct   = 0;
    int        fail_count = 0;
    int        quiet_cycles = 0;

    wire item_taken = start && !busy;

    op_device_placement_tracker_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Work out the placement of one op and advance the shadow state
    function automatic out_item_t place_op(in_item_t op);
        out_item_t        res;
        int               asg;
        logic [DEV_W-1:0] dev;
        logic [ERR_W-1:0] errs;
        int unsigned      rr_dev;
        begin
            res  = '0;
            errs = '0;
            dev  = '0;
            if (op.begin_req)
            begin
                value_seen = '0;
                rr_next    = 0;
            end
            if (n_devices == 0 || n_devices > MAX_DEVICES_DEF || home_device >= n_devices)
            begin
                errs[ERR_CONFIG] = 1'b1;
                res.errors       = errs;
                return res;
            end
            asg = $signed(op.assigned_device);
            if (keep_assigned && op.assigned_device != DEV_UNASSIGNED)
            begin
                dev = op.assigned_device;
                if (asg < 0 || asg >= int'(n_devices))
                    errs[ERR_ASSIGNED] = 1'b1;
            end
            else if (op.kind == KIND_UPLOAD_PLAIN || op.kind == KIND_UPLOAD_CIPHER)
                dev = DEV_W'(home_device);
            else if (op.kind == KIND_COPY_PLAIN || op.kind == KIND_COPY_CIPHER)
            begin
                dev = DEV_W'(home_device);
                errs[ERR_COPY] = 1'b1;
            end
            else if (op.kind == KIND_DOWNLOAD)
            begin
                dev = DEV_W'(home_device);
                if (op.has_input)
                begin
                    if (value_seen[op.first_input_id])
                        dev = value_home[op.first_input_id];
                    else
                        errs[ERR_UNKNOWN] = 1'b1;
                end
            end
            else if (rr_policy == POLICY_ROUND_ROBIN)
            begin
                // A pointer left beyond a lowered count falls back to device 0
                rr_dev  = (rr_next < n_devices) ? rr_next : 0;
                rr_next = (rr_dev + 1 >= n_devices) ? 0 : rr_dev + 1;
                dev     = DEV_W'(rr_dev);
            end
            else
                dev = DEV_W'(home_device);

            // Record the single output value
            if (op.kind != KIND_DOWNLOAD && op.output_count != 0)
            begin
                if (op.output_count != 1)
                    errs[ERR_COUNT] = 1'b1;
                else if (op.out_value_id == 0)
                    errs[ERR_RESERVED] = 1'b1;
                else if (value_seen[op.out_value_id])
                    errs[ERR_DUPLICATE] = 1'b1;
                else
                begin
                    value_seen[op.out_value_id] = 1'b1;
                    value_home[op.out_value_id] = dev;
                end
            end
            res.placed = 1'b1;
            res.device = dev;
            res.errors = errs;
            return res;
        end
    endfunction

    function automatic in_item_t make_op(int bgn, logic [KIND_W-1:0] k,
                                         logic [DEV_W-1:0] asg, int has_in,
                                         int in_id, int cnt, int out_id);
        in_item_t op;
        begin
            op.begin_req       = 1'(bgn);
            op.kind            = k;
            op.assigned_device = asg;
            op.has_input       = 1'(has_in);
            op.first_input_id  = ID_W'(in_id);
            op.output_count    = OCNT_W'(cnt);
            op.out_value_id    = ID_W'(out_id);
            return op;
        end
    endfunction

    // Append one op to the pending queue
    task automatic queue_op(in_item_t op);
        begin
            ops_waiting.insert(ops_waiting.size(), op);
        end
    endtask

    // Mostly well-formed ops over a small id pool, with some raw noise
    function automatic in_item_t random_op();
        in_item_t                 op;
        logic [IN_W-1:0]          raw;
        int                       pick;
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                raw = IN_W'({$urandom, $urandom});
                op  = raw;
                return op;
            end
            op.begin_req = ($urandom_range(0, 99) < 3);
            op.kind      = ($urandom_range(0, 99) < 20) ? KIND_DOWNLOAD
                                                        : KIND_W'($urandom_range(0, 15));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                op.assigned_device = DEV_UNASSIGNED;
            else if (pick < 90)
                op.assigned_device = DEV_W'($urandom_range(0, 15));
            else
                op.assigned_device = DEV_W'($urandom);
            op.has_input      = ($urandom_range(0, 99) < 90);
            op.first_input_id = ($urandom_range(0, 99) < 90) ? ID_W'($urandom_range(0, 63))
                                                             : ID_W'($urandom);
            op.output_count   = ($urandom_range(0, 99) < 80) ? OCNT_W'(1)
                                                             : OCNT_W'($urandom);
            op.out_value_id   = ($urandom_range(0, 99) < 85) ? ID_W'($urandom_range(1, 63))
                                                             : ID_W'($urandom);
            return op;
        end
    endfunction

    // Present pending items, idling at random, and predict each accepted one
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item  <= '0;
        end
        else
        begin
            if (item_taken)
                placement_due.insert(placement_due.size(), place_op(item));
            if (!start || item_taken)
            begin
                if (ops_waiting.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    start <= 1'b1;
                    item  <= ops_waiting.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Compare each result with the oldest placement due
    always @(posedge clk)
    begin
        out_item_t due;
        if (rst_n && done)
        begin
            if (placement_due.size() == 0)
            begin
                $error("result with no item outstanding: %h", result);
                fail_count++;
            end
            else
            begin
                due = placement_due.pop_front();
                if (result.placed !== due.placed)
                begin
                    $error("placed: expected %0d, got %0d", due.placed, result.placed);
                    fail_count++;
                end
                if (result.device !== due.device)
                begin
                    $error("device: expected %0d, got %0d", due.device, result.device);
                    fail_count++;
                end
                if (result.errors !== due.errors)
                begin
                    $error("errors: expected %b, got %b", due.errors, result.errors);
                    fail_count++;
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (item_taken || done || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("op_device_placement_tracker_core test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Hold until every item has been taken and every result has come back
    task automatic drain();
        begin
            @(negedge clk);
            while (ops_waiting.size() != 0 || start || placement_due.size() != 0)
                @(negedge clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= CFG_DATA_W'(val);
            case (idx)
                CFG_DEVICE_COUNT:      n_devices     = val & 32'h1f;
                CFG_DEFAULT_DEVICE:    home_device   = val & 32'hf;
                CFG_POLICY:            rr_policy     = val[0];
                CFG_PRESERVE_ASSIGNED: keep_assigned = val[0];
                default: ;
            endcase
            @(posedge clk);
            cfg_we <= 1'b0;
        end
    endtask

    task automatic set_config(int unsigned cnt, int unsigned dflt, int unsigned pol,
                              int unsigned keep);
        begin
            drain();
            write_reg(CFG_DEVICE_COUNT, cnt);
            write_reg(CFG_DEFAULT_DEVICE, dflt);
            write_reg(CFG_POLICY, pol);
            write_reg(CFG_PRESERVE_ASSIGNED, keep);
            @(negedge clk);
        end
    endtask

    // Phase settings: count, default, policy, preserve
    int unsigned phase_cnt  [RAND_PHASES] = '{16, 5, 1, 16, 8, 0, 31, 4};
    int unsigned phase_dflt [RAND_PHASES] = '{15, 4, 0, 0, 3, 0, 15, 4};
    int unsigned phase_pol  [RAND_PHASES] = '{1, 1, 1, 0, 1, 1, 0, 0};
    int unsigned phase_keep [RAND_PHASES] = '{0, 0, 1, 1, 1, 0, 1, 0};

    initial
    begin
        int pct_set [3];
        int unsigned c;
        pct_set = '{0, 75, 6};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: each kind, the table cases and field extremes
        queue_op(make_op(1, KIND_UPLOAD_PLAIN, DEV_UNASSIGNED, 0, 0, 1, 1));
        queue_op(make_op(0, KIND_UPLOAD_CIPHER, DEV_UNASSIGNED, 0, 0, 1, 1023));
        queue_op(make_op(0, KIND_COPY_PLAIN, DEV_UNASSIGNED, 1, 1, 1, 2));
        queue_op(make_op(0, KIND_COPY_CIPHER, 8'sd0, 1, 1, 1, 3));
        queue_op(make_op(0, KIND_DOWNLOAD, DEV_UNASSIGNED, 1, 1, 0, 0));
        queue_op(make_op(0, KIND_DOWNLOAD, DEV_UNASSIGNED, 1, 5, 1, 0));
        queue_op(make_op(0, KIND_DOWNLOAD, DEV_UNASSIGNED, 0, 1023, 1, 9));
        queue_op(make_op(0, 4'd5, DEV_UNASSIGNED, 1, 2, 1, 0));
        queue_op(make_op(0, 4'd13, DEV_UNASSIGNED, 1, 2, 2, 10));
        queue_op(make_op(0, 4'd14, DEV_UNASSIGNED, 1, 2, 3, 11));
        queue_op(make_op(0, 4'd15, DEV_UNASSIGNED, 1, 2, 1, 1));
        queue_op(make_op(0, 4'd7, 8'sd127, 1, 2, 1, 7));
        queue_op(make_op(0, 4'd8, -8'sd128, 1, 2, 1, 8));
        queue_op(make_op(0, KIND_DOWNLOAD, DEV_UNASSIGNED, 1, 7, 3, 12));
        queue_op(make_op(0, 4'd6, DEV_UNASSIGNED, 1, 7, 0, 0));
        queue_op(make_op(1, KIND_DOWNLOAD, DEV_UNASSIGNED, 1, 1, 1, 1));

        // Round robin, then a lowered count leaves the pointer stale
        set_config(4, 0, 1, 0);
        queue_op(make_op(0, 4'd5, 8'sd2, 1, 1, 1, 20));
        queue_op(make_op(0, 4'd9, DEV_UNASSIGNED, 1, 1, 1, 21));
        queue_op(make_op(0, 4'd14, DEV_UNASSIGNED, 1, 1, 1, 22));
        set_config(2, 0, 1, 0);
        queue_op(make_op(0, 4'd10, DEV_UNASSIGNED, 1, 1, 1, 23));
        queue_op(make_op(0, 4'd11, DEV_UNASSIGNED, 1, 1, 1, 24));

        // Invalid settings place nothing, but begin still clears the table
        set_config(0, 0, 0, 1);
        queue_op(make_op(1, KIND_UPLOAD_PLAIN, DEV_UNASSIGNED, 0, 0, 1, 30));
        set_config(31, 0, 0, 1);
        queue_op(make_op(0, KIND_DOWNLOAD, DEV_UNASSIGNED, 1, 20, 1, 0));
        set_config(4, 4, 0, 1);
        queue_op(make_op(0, 4'd5, 8'sd1, 1, 20, 1, 31));
        set_config(16, 15, 0, 1);
        queue_op(make_op(0, KIND_DOWNLOAD, DEV_UNASSIGNED, 1, 20, 1, 0));

        // Random phases over fixed settings, the last two drawn at random
        for (int ph = 0; ph < RAND_PHASES + 2; ph++)
        begin
            if (ph < RAND_PHASES)
                set_config(phase_cnt[ph], phase_dflt[ph], phase_pol[ph], phase_keep[ph]);
            else
            begin
                c = $urandom_range(1, 16);
                set_config(c, $urandom_range(0, c - 1), $urandom_range(0, 1),
                           $urandom_range(0, 1));
            end
            idle_pct = pct_set[ph % 3];
            for (int i = 0; i < PHASE_ITEMS; i++)
                queue_op(random_op());
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("op_device_placement_tracker_core test passed");
        else
            $display("op_device_placement_tracker_core test failed");
        $finish;
    end

endmodule
